FILE: hdl/keyed_record_table_core_assert.svh
// Assertion macros for the keyed record table core.
`ifndef KEYED_RECORD_TABLE_CORE_ASSERT_SVH
`define KEYED_RECORD_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked property with reset disable
`define KRT_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked property, live through reset
`define KRT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KRT_ASSERT_RST(label, clk, rst_n, prop, msg)
`define KRT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: hdl/krt_pkg.sv
// Shared types and constants for the keyed record table.
package krt_pkg;

  localparam int TABLE_DEPTH_DEF = 32;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_LIST   = 3'd1,
    OP_FIND   = 3'd2,
    OP_UPDATE = 3'd3,
    OP_DELETE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_RUN  = 1'b1
  } fsm_e;

  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         age;
    logic [63:0]        name;
    logic [63:0]        email;
  } rec_t;

endpackage

FILE: hdl/krt_cell.sv
// One ring cell: holds a single record and takes its input record on a shift.
module krt_cell (
  input  logic         clk_i,
  input  logic         en_i,
  input  krt_pkg::rec_t rec_i,
  output krt_pkg::rec_t rec_o
);
  import krt_pkg::*;

  rec_t rec_q;

  // record storage, no reset: contents are valid only below the fill count
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

FILE: hdl/keyed_record_table_core.sv
// Top level: record table built as a rotating ring of record cells.
// Each known command except full-create and empty-list walks the ring once: TABLE_DEPTH steps,
// one step per cycle while the output register is free.
// Full-create and empty-list answer in their first step and end there; unknown opcodes are dropped at once.
// A result shows in the cycle after its step; the ring's single shift path sets the rate.
// Reset (async, active low) clears the fill count and control; record contents stay unknown.
`include "keyed_record_table_core_assert.svh"

module keyed_record_table_core #(
  parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] key_i,
  input  logic [7:0]         age_i,
  input  logic [63:0]        name_word_i,
  input  logic [63:0]        email_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [5:0]         entry_index_o,
  output logic signed [31:0] out_key_o,
  output logic [7:0]         out_age_o,
  output logic [63:0]        out_name_word_o,
  output logic [63:0]        out_email_word_o,
  output logic               last_o
);
  import krt_pkg::*;

  localparam int TW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [TW-1:0] LAST_T = TW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  // control state
  fsm_e          state_q, state_d;
  logic [TW-1:0] t_q, t_d;
  logic [CW-1:0] count_q, count_d;
  logic          found_q, found_d;

  // latched command
  op_e  op_q;
  rec_t cmd_q;

  // output register
  logic    out_valid_q, out_valid_d;
  status_e status_q, status_d;
  logic [5:0] idx_q, idx_d;
  rec_t    orec_q, orec_d;
  logic    last_q, last_d;

  // ring
  rec_t cell_q [TABLE_DEPTH];
  rec_t cell_in [TABLE_DEPTH];
  rec_t head, next1, feed;
  logic ring_en;

  logic step, pass_end, accept;

  assign in_ready_o = (state_q == FSM_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign step       = (state_q == FSM_RUN) && (!out_valid_q || out_ready_i);
  assign head       = cell_q[0];

  // cell chain: each cell takes its upper neighbor, the top cell takes the feed
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_top
      assign cell_in[i] = feed;
    end else begin : g_mid
      assign cell_in[i] = cell_q[i+1];
    end
    krt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (ring_en),
      .rec_i (cell_in[i]),
      .rec_o (cell_q[i])
    );
  end

  // record one place behind the head, used to close the gap on delete
  if (TABLE_DEPTH > 1) begin : g_next
    assign next1 = cell_q[1];
  end else begin : g_next_one
    assign next1 = head;
  end

  // command latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= op_e'(opcode_i);
      cmd_q.key   <= key_i;
      cmd_q.age   <= age_i;
      cmd_q.name  <= name_word_i;
      cmd_q.email <= email_word_i;
    end
  end

  // step decode: feed, result and pass end
  always_comb begin
    logic [CW-1:0] t_ext;
    logic          in_range;
    logic          hit_now;
    logic          emit;
    logic          immediate;
    rec_t          upd;

    t_ext     = CW'(t_q);
    in_range  = t_ext < count_q;
    hit_now   = (op_q == OP_FIND || op_q == OP_UPDATE || op_q == OP_DELETE) &&
                in_range && (head.key == cmd_q.key) && !found_q;
    upd       = cmd_q;
    upd.key   = head.key;
    emit      = 1'b0;
    immediate = 1'b0;
    feed      = head;
    status_d  = ST_OK;
    orec_d    = head;
    last_d    = 1'b1;

    case (op_q)
      OP_CREATE: begin
        if (count_q == FULL_CNT) begin
          immediate = 1'b1;
          emit      = 1'b1;
          status_d  = ST_FULL;
        end else if (t_ext == count_q) begin
          feed   = cmd_q;
          orec_d = cmd_q;
          emit   = 1'b1;
        end
      end
      OP_LIST: begin
        if (count_q == '0) begin
          immediate = 1'b1;
          emit      = 1'b1;
          status_d  = ST_EMPTY;
        end else if (in_range) begin
          emit   = 1'b1;
          last_d = ((t_ext + CW'(1)) == count_q);
        end
      end
      OP_FIND, OP_UPDATE, OP_DELETE: begin
        if (hit_now) begin
          emit = 1'b1;
          if (op_q == OP_UPDATE) begin
            feed   = upd;
            orec_d = upd;
          end
        end else if (!found_q && t_q == LAST_T) begin
          emit     = 1'b1;
          status_d = ST_NOT_FOUND;
        end
        // from the match on, the ring takes the record behind the head
        if (op_q == OP_DELETE && (hit_now || found_q)) begin
          feed = next1;
        end
      end
      default: begin
        immediate = 1'b1;
      end
    endcase

    if (status_d != ST_OK) begin
      orec_d = '0;
    end

    ring_en  = step && !immediate;
    pass_end = step && (immediate || t_q == LAST_T);
    idx_d    = (status_d == ST_OK) ? 6'(t_q) : 6'd0;

    found_d = found_q;
    t_d     = t_q;
    count_d = count_q;
    if (accept) begin
      found_d = 1'b0;
      t_d     = '0;
    end else if (step) begin
      found_d = found_q || hit_now;
      t_d     = (t_q == LAST_T) ? '0 : t_q + TW'(1);
    end
    if (pass_end) begin
      if (op_q == OP_CREATE && !immediate) begin
        count_d = count_q + CW'(1);
      end else if (op_q == OP_DELETE && (found_q || hit_now)) begin
        count_d = count_q - CW'(1);
      end
    end

    out_valid_d = out_valid_q;
    if (step && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept && (opcode_i inside {OP_CREATE, OP_LIST, OP_FIND, OP_UPDATE, OP_DELETE})) begin
          state_d = FSM_RUN;
        end
      end
      FSM_RUN: begin
        if (pass_end) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      t_q         <= '0;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      count_q     <= count_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      status_q <= status_d;
      idx_q    <= idx_d;
      orec_q   <= orec_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign entry_index_o    = idx_q;
  assign out_key_o        = orec_q.key;
  assign out_age_o        = orec_q.age;
  assign out_name_word_o  = orec_q.name;
  assign out_email_word_o = orec_q.email;
  assign last_o           = last_q;

  // checks
  `KRT_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni |-> count_q <= FULL_CNT, "count above depth")
  `KRT_ASSERT_RST(a_pass_done, clk_i, rst_ni, pass_end |=> state_q == FSM_IDLE, "pass did not end")
  `KRT_ASSERT_RST(a_count_at_end, clk_i, rst_ni, !$stable(count_q) |-> $past(pass_end), "count moved mid pass")
  `KRT_ASSERT_RST(a_ring_run, clk_i, rst_ni, ring_en |-> state_q == FSM_RUN && step, "ring shifted while idle")

endmodule

FILE: verif/keyed_record_table_checker.sv
`timescale 1ns / 1ps
// Reply checker for the keyed record table: tracks the table contents and compares every reply.
module keyed_record_table_checker #(
  parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] key_i,
  input  logic [7:0]         age_i,
  input  logic [63:0]        name_word_i,
  input  logic [63:0]        email_word_i,
  // reply channel
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         status_i,
  input  logic [5:0]         entry_index_i,
  input  logic signed [31:0] out_key_i,
  input  logic [7:0]         out_age_i,
  input  logic [63:0]        out_name_word_i,
  input  logic [63:0]        out_email_word_i,
  input  logic               last_i,
  // tallies for the top
  output int                 fail_cnt_o,
  output int                 pending_o,
  output int                 beat_cnt_o,
  output int                 full_cnt_o,
  output int                 miss_cnt_o,
  output int                 empty_cnt_o
);
  import krt_pkg::*;

  typedef struct {
    status_e    status;
    logic [5:0] index;
    rec_t       rec;
    logic       last;
  } reply_t;

  // Shadow copy of the table
  rec_t   rows [TABLE_DEPTH];
  int     row_cnt = 0;
  reply_t reply_q [$];

  int fails = 0;
  int beats = 0;
  int fulls = 0;
  int misses = 0;
  int empties = 0;

  // Failing replies carry zero index and record
  task automatic queue_reply(input status_e st, input int idx, input rec_t rec,
                             input logic is_last);
    reply_t r;
    r.status = st;
    r.index  = (st == ST_OK) ? 6'(idx) : '0;
    r.rec    = (st == ST_OK) ? rec : '0;
    r.last   = is_last;
    reply_q.push_back(r);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fails++;
    end
  endtask

  // Work out the replies of one accepted command and update the shadow table
  task automatic predict_cmd();
    rec_t cmd;
    int   hit;
    cmd.key   = key_i;
    cmd.age   = age_i;
    cmd.name  = name_word_i;
    cmd.email = email_word_i;
    case (opcode_i)
      OP_CREATE: begin
        if (row_cnt >= TABLE_DEPTH) begin
          queue_reply(ST_FULL, 0, '0, 1'b1);
        end else begin
          rows[row_cnt] = cmd;
          queue_reply(ST_OK, row_cnt, cmd, 1'b1);
          row_cnt++;
        end
      end
      OP_LIST: begin
        if (row_cnt == 0) begin
          queue_reply(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (int i = 0; i < row_cnt; i++)
            queue_reply(ST_OK, i, rows[i], i == row_cnt - 1);
        end
      end
      OP_FIND, OP_UPDATE, OP_DELETE: begin
        // first match wins: scan from the top down
        hit = row_cnt;
        for (int i = row_cnt - 1; i >= 0; i--)
          if (rows[i].key == cmd.key) hit = i;
        if (hit == row_cnt) begin
          queue_reply(ST_NOT_FOUND, 0, '0, 1'b1);
        end else begin
          if (opcode_i == OP_UPDATE) begin
            rows[hit].age   = cmd.age;
            rows[hit].name  = cmd.name;
            rows[hit].email = cmd.email;
          end
          queue_reply(ST_OK, hit, rows[hit], 1'b1);
          if (opcode_i == OP_DELETE) begin
            for (int i = hit; i + 1 < row_cnt; i++) rows[i] = rows[i + 1];
            row_cnt--;
          end
        end
      end
      default: ; // unused opcodes are dropped without a reply
    endcase
  endtask

  task automatic check_reply();
    reply_t want;
    beats++;
    if (reply_q.size() == 0) begin
      $display("%0t: reply beat with none expected, status %0d index %0d key %0h",
               $time, status_i, entry_index_i, out_key_i);
      fails++;
    end else begin
      want = reply_q.pop_front();
      check_field("status", want.status, status_i);
      check_field("entry_index", want.index, entry_index_i);
      check_field("out_key", want.rec.key, out_key_i);
      check_field("out_age", want.rec.age, out_age_i);
      check_field("out_name_word", want.rec.name, out_name_word_i);
      check_field("out_email_word", want.rec.email, out_email_word_i);
      check_field("last", want.last, last_i);
      case (want.status)
        ST_FULL:      fulls++;
        ST_NOT_FOUND: misses++;
        ST_EMPTY:     empties++;
        default:      ;
      endcase
    end
  endtask

  // Replies first, so a beat can never match a command taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt = 0;
      reply_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_reply();
      if (in_valid_i && in_ready_i) predict_cmd();
    end
    fail_cnt_o  <= fails;
    pending_o   <= reply_q.size();
    beat_cnt_o  <= beats;
    full_cnt_o  <= fulls;
    miss_cnt_o  <= misses;
    empty_cnt_o <= empties;
  end

endmodule

FILE: verif/keyed_record_table_core_test.sv
`timescale 1ns / 1ps
// Testbench top for the keyed record table core: command stimulus, output pacing and verdict.
module keyed_record_table_core_test;
  import krt_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int NUM_CMDS    = 360;
  localparam int HOLD_AT     = 150;  // command count that starts the long output hold-off
  localparam int HOLD_CYCLES = 400;

  localparam logic [2:0]         OP_UNUSED_FIRST = 3'(OP_DELETE) + 3'd1;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic [63:0]        WORD_ONES = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // command channel
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         cmd_op = '0;
  logic signed [31:0] cmd_key = '0;
  logic [7:0]         cmd_age = '0;
  logic [63:0]        cmd_name = '0;
  logic [63:0]        cmd_email = '0;

  // reply channel
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         rsp_status;
  logic [5:0]         rsp_index;
  logic signed [31:0] rsp_key;
  logic [7:0]         rsp_age;
  logic [63:0]        rsp_name;
  logic [63:0]        rsp_email;
  logic               rsp_last;

  int fail_cnt, pending, beat_cnt, full_cnt, miss_cnt, empty_cnt;

  int sent = 0;
  int op_cnt [8];
  int burst_left = 0;
  logic signed [31:0] key_pool [8];
  logic signed [31:0] made_keys [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  keyed_record_table_core #(.TABLE_DEPTH(DEPTH)) DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .opcode_i         (cmd_op),
    .key_i            (cmd_key),
    .age_i            (cmd_age),
    .name_word_i      (cmd_name),
    .email_word_i     (cmd_email),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (rsp_status),
    .entry_index_o    (rsp_index),
    .out_key_o        (rsp_key),
    .out_age_o        (rsp_age),
    .out_name_word_o  (rsp_name),
    .out_email_word_o (rsp_email),
    .last_o           (rsp_last)
  );

  keyed_record_table_checker #(.TABLE_DEPTH(DEPTH)) u_table_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .opcode_i         (cmd_op),
    .key_i            (cmd_key),
    .age_i            (cmd_age),
    .name_word_i      (cmd_name),
    .email_word_i     (cmd_email),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .status_i         (rsp_status),
    .entry_index_i    (rsp_index),
    .out_key_i        (rsp_key),
    .out_age_i        (rsp_age),
    .out_name_word_i  (rsp_name),
    .out_email_word_i (rsp_email),
    .last_i           (rsp_last),
    .fail_cnt_o       (fail_cnt),
    .pending_o        (pending),
    .beat_cnt_o       (beat_cnt),
    .full_cnt_o       (full_cnt),
    .miss_cnt_o       (miss_cnt),
    .empty_cnt_o      (empty_cnt)
  );

  // Offer one command and hold it until the beat is taken; then pace the next burst
  task automatic send_cmd(input logic [2:0] op, input logic signed [31:0] key,
                          input logic [7:0] age, input logic [63:0] nm,
                          input logic [63:0] em);
    in_valid  <= 1'b1;
    cmd_op    <= op;
    cmd_key   <= key;
    cmd_age   <= age;
    cmd_name  <= nm;
    cmd_email <= em;
    do @(posedge clk); while (!in_ready);
    sent++;
    op_cnt[op]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Stop offering until every outstanding reply has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Reply side: ready pattern changes mode now and then, with one long hold-off
  initial begin
    int unsigned mode, span;
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(40, 160);
      repeat (span) begin
        @(posedge clk);
        if (!held && sent >= HOLD_AT) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          held = 1'b1;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Command side
  initial begin
    int unsigned kind, span, roll, episode, next_pause;
    int unsigned cut [5];
    logic [2:0] op;
    logic signed [31:0] k;

    foreach (op_cnt[i]) op_cnt[i] = 0;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, field extremes, duplicates, first match, shifts, unused opcodes
    send_cmd(OP_LIST, '0, '0, '0, '0);
    send_cmd(OP_FIND, '0, '0, '0, '0);
    send_cmd(OP_UPDATE, -32'sd1, 8'hff, WORD_ONES, WORD_ONES);
    send_cmd(OP_DELETE, KEY_MAX, '0, '0, '0);
    send_cmd(OP_CREATE, KEY_MIN, 8'h00, '0, '0);
    send_cmd(OP_CREATE, KEY_MAX, 8'hff, WORD_ONES, WORD_ONES);
    send_cmd(OP_CREATE, '0, 8'h5a, {$urandom, $urandom}, {$urandom, $urandom});
    send_cmd(OP_CREATE, KEY_MIN, 8'ha5, {$urandom, $urandom}, {$urandom, $urandom});
    send_cmd(OP_CREATE, -32'sd1, 8'h7f, {$urandom, $urandom}, {$urandom, $urandom});
    send_cmd(OP_FIND, KEY_MIN, '0, '0, '0);
    send_cmd(OP_UPDATE, KEY_MIN, 8'h80, {$urandom, $urandom}, {$urandom, $urandom});
    send_cmd(OP_LIST, '0, '0, '0, '0);
    send_cmd(OP_DELETE, '0, '0, '0, '0);
    send_cmd(OP_FIND, -32'sd1, '0, '0, '0);
    send_cmd(OP_DELETE, KEY_MIN, '0, '0, '0);
    send_cmd(OP_FIND, KEY_MIN, '0, '0, '0);
    for (int u = OP_UNUSED_FIRST; u < 8; u++)
      send_cmd(3'(u), KEY_MAX, 8'hff, WORD_ONES, WORD_ONES);
    send_cmd(OP_LIST, '0, '0, '0, '0);
    send_cmd(OP_DELETE, KEY_MAX, '0, '0, '0);
    send_cmd(OP_DELETE, KEY_MIN, '0, '0, '0);
    send_cmd(OP_DELETE, -32'sd1, '0, '0, '0);
    send_cmd(OP_LIST, '0, '0, '0, '0);
    send_cmd(OP_FIND, -32'sd1, '0, '0, '0);

    // Random: episodes that fill, churn and drain the table in turn
    episode = 0;
    next_pause = 100;
    while (sent < NUM_CMDS) begin
      kind = episode % 3;
      episode++;
      case (kind)
        0:       cut = '{70, 78, 86, 93, 99};
        1:       cut = '{30, 40, 58, 72, 96};
        default: cut = '{10, 18, 30, 40, 99};
      endcase
      span = $urandom_range(30, 60);
      repeat (span) begin
        if (sent >= NUM_CMDS) break;
        if (sent >= next_pause) begin
          wait_drained();
          next_pause += 160;
        end
        roll = $urandom_range(0, 99);
        if (roll < cut[0]) op = OP_CREATE;
        else if (roll < cut[1]) op = OP_LIST;
        else if (roll < cut[2]) op = OP_FIND;
        else if (roll < cut[3]) op = OP_UPDATE;
        else if (roll < cut[4]) op = OP_DELETE;
        else op = OP_UNUSED_FIRST + 3'($urandom_range(0, 2));
        // mostly keys that are likely stored, some fully random
        roll = $urandom_range(0, 99);
        if (roll < 12) k = $urandom;
        else if (roll < 45 && made_keys.size() != 0)
          k = made_keys[$urandom_range(0, made_keys.size() - 1)];
        else k = key_pool[$urandom_range(0, 7)];
        if (op == OP_CREATE) begin
          made_keys.push_back(k);
          if (made_keys.size() > DEPTH) void'(made_keys.pop_front());
        end
        send_cmd(op, k, 8'($urandom_range(0, 255)), {$urandom, $urandom},
                 {$urandom, $urandom});
      end
    end

    // Let the last replies and any trailing walk finish
    wait_drained();
    repeat (2 * DEPTH + 8) @(posedge clk);

    $display("Run covered %0d commands: create %0d, list %0d, find %0d, update %0d, delete %0d",
             sent, op_cnt[OP_CREATE], op_cnt[OP_LIST], op_cnt[OP_FIND],
             op_cnt[OP_UPDATE], op_cnt[OP_DELETE]);
    $display("%0d unused opcodes; %0d reply beats checked (%0d full, %0d not found, %0d empty)",
             sent - op_cnt[OP_CREATE] - op_cnt[OP_LIST] - op_cnt[OP_FIND]
             - op_cnt[OP_UPDATE] - op_cnt[OP_DELETE],
             beat_cnt, full_cnt, miss_cnt, empty_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("Timeout with %0d replies outstanding", pending);
    $display("status: fail");
    $finish;
  end

endmodule
